// ===== rtl/ggk_pkg.sv =====
package ggk_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned RegW  = 64;
  localparam int unsigned Rows  = 8;
  localparam int unsigned RoundCntW = 5;

  localparam logic [WordW-1:0] GammaC1 = 32'd16843009;
  localparam logic [WordW-1:0] GammaC2 = 32'd16843012;
  localparam int unsigned RotLeft = 11;

  typedef enum logic [1:0] {
    OP_CRYPT   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } ggk_op_t;

  typedef enum logic [2:0] {
    REG_KEY01 = 3'd0,
    REG_KEY23 = 3'd1,
    REG_KEY45 = 3'd2,
    REG_KEY67 = 3'd3,
    REG_IV    = 3'd4
  } ggk_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_SWAP
  } ggk_state_t;

  // controls from the sequencer to the round datapath
  typedef struct packed {
    logic             load_iv;
    logic             advance;
    logic             round;
    logic             swap;
    logic [WordW-1:0] key_word;
    logic [RegW-1:0]  iv;
  } ggk_ctrl_t;

endpackage

// ===== rtl/ggk_core.sv =====
module ggk_core (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  ggk_pkg::ggk_ctrl_t                       ctrl,
  input  logic [ggk_pkg::Rows-1:0][ggk_pkg::RegW-1:0] sbox_rows,
  output logic [ggk_pkg::WordW-1:0]                n1,
  output logic [ggk_pkg::WordW-1:0]                n2
);
  import ggk_pkg::*;

  logic [WordW-1:0] n1_r, n1_nxt;
  logic [WordW-1:0] n2_r, n2_nxt;
  logic [WordW-1:0] kw_sum;
  logic [WordW-1:0] sub;
  logic [WordW-1:0] rot;
  logic [WordW-1:0] round_out;
  logic [WordW:0]   n2_sum;
  logic [WordW-1:0] n2_adv;

  // one GOST round: key add, S-box layer, rotate, xor
  always_comb begin
    kw_sum = ctrl.key_word + n1_r;
    for (int i = 0; i < Rows; i++) begin
      sub[4*i +: 4] = sbox_rows[i][{kw_sum[4*i +: 4], 2'b00} +: 4];
    end
    rot       = {sub[WordW-RotLeft-1:0], sub[WordW-1:WordW-RotLeft]};
    round_out = rot ^ n2_r;
  end

  // N2 + C2 mod (2^32 - 1), kept in 1..2^32-1
  always_comb begin
    n2_sum = {1'b0, n2_r} + {1'b0, GammaC2};
    n2_adv = n2_sum[WordW] ? (n2_sum[WordW-1:0] + 32'd1) : n2_sum[WordW-1:0];
  end

  always_comb begin
    n1_nxt = n1_r;
    n2_nxt = n2_r;
    priority if (ctrl.load_iv) begin
      n1_nxt = ctrl.iv[WordW-1:0];
      n2_nxt = ctrl.iv[RegW-1:WordW];
    end else if (ctrl.advance) begin
      n1_nxt = n1_r + GammaC1;
      n2_nxt = n2_adv;
    end else if (ctrl.round) begin
      n1_nxt = round_out;
      n2_nxt = n1_r;
    end else if (ctrl.swap) begin
      n1_nxt = n2_r;
      n2_nxt = n1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_r <= '0;
      n2_r <= '0;
    end else begin
      n1_r <= n1_nxt;
      n2_r <= n2_nxt;
    end
  end

  assign n1 = n1_r;
  assign n2 = n2_r;

endmodule

// ===== rtl/gost_gamma_keystream_xor_unit.sv =====
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready  | in_tuser: operation; in_tdata: byte, row, row value
// out_    | out | out_tvalid/out_tready| out_tdata: out_byte
// cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
// Crypt at byte positions 1..7, S-box loads and unused codes run no rounds.
// Restart and the crypt that opens a block run 32 rounds on one shared round
// unit, then a swap step that exchanges N1 and N2.
// Reset clears the counter, byte position and registers; S-box rows are not reset.
// in_tready is low while rounds and the swap run, and also while a result waits and out_tready is low.
module gost_gamma_keystream_xor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // data_byte[7:0], sbox_row[10:8], sbox_row_value[74:11]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ggk_pkg::*;

  logic [RegW-1:0] key01_r, key23_r, key45_r, key67_r, iv_r;
  logic [Rows-1:0][RegW-1:0] sbox_r;

  ggk_state_t state_r, state_nxt;
  logic [RoundCntW-1:0] rnd_r, rnd_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        pend_crypt_r, pend_crypt_nxt;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r, out_data_nxt;

  ggk_op_t     op;
  logic        in_fire;
  logic [7:0]  in_byte;
  logic [2:0]  in_row;
  logic [RegW-1:0] in_row_val;
  logic [2:0]  key_idx;
  logic [RegW-1:0] key_pair;
  logic [WordW-1:0] n1, n2, half;
  ggk_ctrl_t   ctrl;

  assign op         = ggk_op_t'(in_tuser);
  assign in_byte    = in_tdata[7:0];
  assign in_row     = in_tdata[10:8];
  assign in_row_val = in_tdata[74:11];
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r <= '0;
      key23_r <= '0;
      key45_r <= '0;
      key67_r <= '0;
      iv_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY01: key01_r <= cfg_data;
        REG_KEY23: key23_r <= cfg_data;
        REG_KEY45: key45_r <= cfg_data;
        REG_KEY67: key67_r <= cfg_data;
        REG_IV:    iv_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && op == OP_LOAD) begin
      sbox_r[in_row] <= in_row_val;
    end
  end

  // key schedule: words 0..7 three times, then 7..0
  always_comb begin
    key_idx = (rnd_r[4:3] == 2'b11) ? ~rnd_r[2:0] : rnd_r[2:0];
    unique case (key_idx[2:1])
      2'd0: key_pair = key01_r;
      2'd1: key_pair = key23_r;
      2'd2: key_pair = key45_r;
      default: key_pair = key67_r;
    endcase
  end

  always_comb begin
    half = pos_r[2] ? n2 : n1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (op == OP_RESTART || (op == OP_CRYPT && pos_r == 3'd0))) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: if (&rnd_r) state_nxt = ST_SWAP;
      ST_SWAP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath controls and outputs
  always_comb begin
    ctrl           = '0;
    ctrl.iv        = iv_r;
    ctrl.key_word  = key_idx[0] ? key_pair[RegW-1:WordW] : key_pair[WordW-1:0];
    rnd_nxt        = rnd_r;
    pos_nxt        = pos_r;
    pend_crypt_nxt = pend_crypt_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        rnd_nxt = '0;
        if (in_fire) begin
          unique case (op)
            OP_RESTART: begin
              ctrl.load_iv   = 1'b1;
              pos_nxt        = 3'd0;
              pend_crypt_nxt = 1'b0;
            end
            OP_CRYPT: begin
              pos_nxt = pos_r + 3'd1;
              if (pos_r == 3'd0) begin
                ctrl.advance   = 1'b1;
                pend_crypt_nxt = 1'b1;
                pend_byte_nxt  = in_byte;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = in_byte ^ half[{pos_r[1:0], 3'b000} +: 8];
              end
            end
            OP_LOAD: ;
            OP_NONE: ;
            default: ;
          endcase
        end
      end
      ST_ROUND: begin
        ctrl.round = 1'b1;
        rnd_nxt    = rnd_r + 5'd1;
      end
      ST_SWAP: begin
        ctrl.swap = 1'b1;
        if (pend_crypt_r) begin
          // byte 0 of the new block is the low byte of N2 before the swap
          out_valid_nxt = 1'b1;
          out_data_nxt  = pend_byte_r ^ n2[7:0];
        end
        pend_crypt_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rnd_r        <= '0;
      pos_r        <= '0;
      pend_crypt_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rnd_r        <= rnd_nxt;
      pos_r        <= pos_nxt;
      pend_crypt_r <= pend_crypt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  ggk_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .sbox_rows (sbox_r),
    .n1        (n1),
    .n2        (n2)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_out_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !out_valid_r)
    else $error("result pending while rounds run");

  a_restart_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_RESTART) |=> (state_r == ST_ROUND && rnd_r == '0))
    else $error("restart did not start round sequence");

  a_swap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && (&rnd_r)) |=> (state_r == ST_SWAP))
    else $error("swap did not follow last round");

  a_mid_block_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && op == OP_CRYPT && pos_r != 3'd0) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("mid-block crypt gave no result");

endmodule

// ===== tb/tb_gost_gamma_keystream_xor_unit.sv =====
`timescale 1ns / 100ps

module tb_gost_gamma_keystream_xor_unit;
  import ggk_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 48;   // restart: the rounds and swap, plus a margin
  localparam int unsigned MAX_WAIT       = 12;
  localparam int unsigned PHASE_ITEMS    = 300;
  localparam logic [63:0] N2_MODULUS     = 64'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // data_byte[7:0], sbox_row[10:8], sbox_row_value[74:11]
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // out_byte[7:0]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  gost_gamma_keystream_xor_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // gamma-mode state mirror
  logic [63:0] reg_shadow [5];
  logic [63:0] sbox_rows  [8];
  logic [31:0] ctr_n1;
  logic [31:0] ctr_n2;
  logic [2:0]  byte_pos;

  logic [7:0] expected_out_bytes [$];
  int unsigned mismatch_count;
  bit in_gaps_on;
  bit out_stalls_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned draw_wait(input bit enabled);
    return enabled ? $urandom_range(0, MAX_WAIT) : 0;
  endfunction

  function automatic void gost_round(input int unsigned widx);
    logic [63:0] pair;
    logic [31:0] mixed;
    logic [31:0] subst;
    pair  = reg_shadow[widx >> 1];
    mixed = (widx[0] ? pair[63:32] : pair[31:0]) + ctr_n1;
    for (int i = 0; i < 8; i++) begin
      subst[4*i +: 4] = sbox_rows[i][4*mixed[4*i +: 4] +: 4];
    end
    subst  = {subst[20:0], subst[31:21]};
    subst  = subst ^ ctr_n2;
    ctr_n2 = ctr_n1;
    ctr_n1 = subst;
  endfunction

  function automatic void encrypt_counter();
    logic [31:0] tmp;
    for (int p = 0; p < 3; p++) begin
      for (int j = 0; j < 8; j++) gost_round(j);
    end
    for (int j = 7; j >= 0; j--) gost_round(j);
    tmp    = ctr_n1;
    ctr_n1 = ctr_n2;
    ctr_n2 = tmp;
  endfunction

  function automatic void gamma_predict_item(input ggk_op_t op, input logic [7:0] data_b,
                                             input logic [2:0] row, input logic [63:0] row_val);
    logic [63:0] sum;
    logic [31:0] half;
    logic [7:0]  ks;
    case (op)
      OP_LOAD: begin
        sbox_rows[row] = row_val;
      end
      OP_RESTART: begin
        ctr_n1 = reg_shadow[REG_IV][31:0];
        ctr_n2 = reg_shadow[REG_IV][63:32];
        encrypt_counter();
        byte_pos = 3'd0;
      end
      OP_CRYPT: begin
        if (byte_pos == 3'd0) begin
          sum    = {32'd0, ctr_n2} + {32'd0, GammaC2};
          ctr_n1 = ctr_n1 + GammaC1;
          sum    = (sum - 64'd1) % N2_MODULUS + 64'd1;
          ctr_n2 = sum[31:0];
          encrypt_counter();
        end
        half = (byte_pos < 3'd4) ? ctr_n1 : ctr_n2;
        ks   = half[8*byte_pos[1:0] +: 8];
        expected_out_bytes.push_back(data_b ^ ks);
        byte_pos = byte_pos + 3'd1;
      end
      default: ;  // unused code: no state change, no result
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  // in_tvalid is left high after a transaction so a back-to-back item needs one assignment
  task automatic send_item(input ggk_op_t op, input logic [7:0] data_b,
                           input logic [2:0] row, input logic [63:0] row_val);
    int unsigned gap;
    gap = draw_wait(in_gaps_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, row_val, row, data_b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gamma_predict_item(op, data_b, row, row_val);
  endtask

  task automatic send_random(input ggk_op_t op);
    send_item(op, 8'($urandom), 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic in_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_idle();
    while (expected_out_bytes.size() > 0) @(posedge clk);
  endtask

  task automatic wait_block_idle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input ggk_reg_t idx, input logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    reg_shadow[idx] = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [63:0] k01, input logic [63:0] k23,
                                input logic [63:0] k45, input logic [63:0] k67,
                                input logic [63:0] iv);
    wait_block_idle();
    cfg_write(REG_KEY01, k01);
    cfg_write(REG_KEY23, k23);
    cfg_write(REG_KEY45, k45);
    cfg_write(REG_KEY67, k67);
    cfg_write(REG_IV, iv);
  endtask

  // result side: random stalls, compare against oldest expected byte
  initial begin
    int unsigned stall;
    logic [7:0] want;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait(out_stalls_on);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (expected_out_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected out transaction, out_byte %02h", out_tdata));
      end else begin
        want = expected_out_bytes.pop_front();
        if (out_tdata !== want)
          report_mismatch($sformatf("out_byte got %02h want %02h", out_tdata, want));
      end
    end
  end

  // watchdog: cycles with no transaction on either stream
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // every row written first, so no round ever reads an unwritten row
  task automatic test_sbox_load();
    send_item(OP_LOAD, 8'h00, 3'd0, 64'h0);
    for (int r = 1; r < 7; r++) send_random(OP_LOAD);
    for (int r = 1; r < 7; r++) begin
      send_item(OP_LOAD, 8'($urandom), 3'(r), {$urandom, $urandom});
    end
    send_item(OP_LOAD, 8'hFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // counter is still zero from reset
  task automatic test_crypt_before_restart();
    send_item(OP_CRYPT, 8'h00, 3'd0, 64'h0);
    send_item(OP_CRYPT, 8'hFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_unused_code();
    send_random(OP_NONE);
    send_random(OP_CRYPT);
  endtask

  // restart, then a full block and the first byte of the next one
  task automatic test_restart_block();
    send_random(OP_RESTART);
    for (int i = 0; i < 9; i++) begin
      send_item(OP_CRYPT, (i % 2 == 0) ? 8'h00 : 8'hFF, 3'($urandom), {$urandom, $urandom});
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_random(OP_RESTART);
        run_len = $urandom_range(1, 20);
        repeat (run_len) send_random(OP_CRYPT);
        sent += run_len + 1;
      end else if (kind < 80) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) send_random(OP_CRYPT);
        sent += run_len;
      end else if (kind < 90) begin
        send_random(OP_LOAD);
        sent++;
      end else if (kind < 97) begin
        send_random(OP_NONE);
      end else begin
        hold_until_drained();
      end
    end
  endtask

  task automatic test_config_sweep();
    for (int ph = 0; ph < 6; ph++) begin
      in_gaps_on    = ph[0];
      out_stalls_on = ph[1] | (ph >= 4);
      case (ph)
        0: write_all_regs(64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        1: write_all_regs({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}});
        2: write_all_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {32'hFFFF_FFFF, $urandom});
        default: write_all_regs({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom});
      endcase
      run_traffic(PHASE_ITEMS);
      hold_until_drained();
    end
  endtask

  initial begin
    mismatch_count = 0;
    in_gaps_on     = 1'b1;
    out_stalls_on  = 1'b1;
    ctr_n1   = 32'd0;
    ctr_n2   = 32'd0;
    byte_pos = 3'd0;
    for (int r = 0; r < 5; r++) reg_shadow[r] = 64'd0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 80'd0;
    in_tuser  <= OP_CRYPT;
    cfg_we    <= 1'b0;
    cfg_index <= REG_KEY01;
    cfg_data  <= 64'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_sbox_load();
    test_crypt_before_restart();
    test_unused_code();
    test_restart_block();
    test_config_sweep();

    wait_block_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
